>>> design/bounded_sorted_priority_queue_core_macros.svh
// Assertion macros shared by the queue checker.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef BOUNDED_SORTED_PRIORITY_QUEUE_CORE_MACROS_SVH
`define BOUNDED_SORTED_PRIORITY_QUEUE_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BSPQ_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BSPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/bspq_pkg.sv
// ----------------------------------------------------------------------------
// bspq_pkg
// Types, codes and default sizes for the bounded sorted priority queue.
// ----------------------------------------------------------------------------
package bspq_pkg;

	localparam int QUEUE_DEPTH_DEF  = 128;
	localparam int PAYLOAD_BITS_DEF = 32;
	localparam int KEY_BITS_DEF     = 16;
	localparam int COUNT_OUT_BITS   = 8;

	// Operation codes on the operation port.
	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_PUSHED      = 2'd0,
		ST_PUSHED_DROP = 2'd1,
		ST_POPPED      = 2'd2,
		ST_POP_EMPTY   = 2'd3
	} bspq_status_t;

	// Command broadcast to every cell of the row.
	typedef struct packed {
		logic push;
		logic pop;
	} bspq_cmd_t;

endpackage

>>> design/bspq_cell.sv
// ----------------------------------------------------------------------------
// bspq_cell
// One position of the sorted row: holds a key and payload and either keeps
// them, takes the new entry, or takes a neighbor's entry.
// ----------------------------------------------------------------------------
module bspq_cell #(
	parameter int KEY_BITS     = bspq_pkg::KEY_BITS_DEF,
	parameter int PAYLOAD_BITS = bspq_pkg::PAYLOAD_BITS_DEF,
	parameter int COUNT_W      = 8,
	parameter int INDEX        = 0
) (
	input  logic                        clk,
	input  bspq_pkg::bspq_cmd_t         cmd,
	input  logic [COUNT_W-1:0]          fill,
	input  logic signed [KEY_BITS-1:0]  new_key,
	input  logic [PAYLOAD_BITS-1:0]     new_payload,
	input  logic                        left_gt,
	input  logic signed [KEY_BITS-1:0]  left_key,
	input  logic [PAYLOAD_BITS-1:0]     left_payload,
	input  logic signed [KEY_BITS-1:0]  right_key,
	input  logic [PAYLOAD_BITS-1:0]     right_payload,
	output logic                        gt,
	output logic signed [KEY_BITS-1:0]  key,
	output logic [PAYLOAD_BITS-1:0]     payload
);

	logic signed [KEY_BITS-1:0] key_q;
	logic [PAYLOAD_BITS-1:0]    payload_q;
	logic                       occupied;
	logic                       at_end;

	assign occupied = COUNT_W'(INDEX) < fill;
	assign at_end   = COUNT_W'(INDEX) == fill;

	// This cell's entry must move right when the new key is strictly lower.
	assign gt = occupied && (new_key < key_q);

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			if (left_gt) begin
				key_q     <= left_key;
				payload_q <= left_payload;
			end else if (gt || at_end) begin
				key_q     <= new_key;
				payload_q <= new_payload;
			end
		end else if (cmd.pop) begin
			key_q     <= right_key;
			payload_q <= right_payload;
		end
	end

	assign key     = key_q;
	assign payload = payload_q;

endmodule

>>> design/bounded_sorted_priority_queue_core.sv
// ----------------------------------------------------------------------------
// bounded_sorted_priority_queue_core
// Bounded priority queue kept sorted in a row of shifting cells.
// ----------------------------------------------------------------------------
// The queue holds up to QUEUE_DEPTH entries sorted by ascending signed key,
// with equal keys leaving in arrival order. A transfer is taken at every
// rising edge where start is high and busy is low; busy is held low, so a
// push or pop may be issued in every clock cycle. Each transfer produces
// exactly one result, shown on the result ports with done high for exactly
// one cycle, in the cycle right after the transfer. The receiver cannot stall
// these results, so it must take each one in the cycle it appears. Every
// cell of the row compares the new key with its own and shifts or loads
// in parallel in the same edge. A push into a full queue drops the last
// entry and reports status 1. A pop on an empty queue reports status 3
// and leaves the queue unchanged. The count port shows the low eight bits
// of the fill level after the reported operation. Entry storage is not
// cleared at reset; only positions below the fill level are ever read.
// ----------------------------------------------------------------------------
module bounded_sorted_priority_queue_core #(
	parameter int QUEUE_DEPTH  = bspq_pkg::QUEUE_DEPTH_DEF,
	parameter int PAYLOAD_BITS = bspq_pkg::PAYLOAD_BITS_DEF,
	parameter int KEY_BITS     = bspq_pkg::KEY_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic                                 operation,
	input  logic signed [KEY_BITS-1:0]           priority_req,
	input  logic [PAYLOAD_BITS-1:0]              payload,
	output logic                                 done,
	output logic [1:0]                           status,
	output logic signed [KEY_BITS-1:0]           popped_priority,
	output logic [PAYLOAD_BITS-1:0]              popped_payload,
	output logic [bspq_pkg::COUNT_OUT_BITS-1:0]  count
);

	import bspq_pkg::*;

	localparam int CountW = $clog2(QUEUE_DEPTH + 1);

	// Fill level and result registers.
	logic [CountW-1:0]           count_q;
	logic                        done_q;
	bspq_status_t                status_q;
	logic signed [KEY_BITS-1:0]  ppri_q;
	logic [PAYLOAD_BITS-1:0]     ppay_q;

	logic                        accept;
	logic                        full;
	logic                        empty;
	logic [CountW-1:0]           fill;
	bspq_cmd_t                   cmd;

	// Per-cell wiring of the row.
	logic                        gt_w   [QUEUE_DEPTH];
	logic signed [KEY_BITS-1:0]  key_w  [QUEUE_DEPTH];
	logic [PAYLOAD_BITS-1:0]     pay_w  [QUEUE_DEPTH];
	logic                        lgt_w  [QUEUE_DEPTH];
	logic signed [KEY_BITS-1:0]  lkey_w [QUEUE_DEPTH];
	logic [PAYLOAD_BITS-1:0]     lpay_w [QUEUE_DEPTH];
	logic signed [KEY_BITS-1:0]  rkey_w [QUEUE_DEPTH];
	logic [PAYLOAD_BITS-1:0]     rpay_w [QUEUE_DEPTH];

	// Every cell of the row updates in parallel, so the core never needs to
	// hold off the requester.
	assign busy   = 1'b0;
	assign accept = start && !busy;

	assign full  = count_q == CountW'(QUEUE_DEPTH);
	assign empty = count_q == '0;

	// On a full push the last position is treated as free, which drops the
	// worst entry and lets the new one land there or shift it out.
	assign fill = full ? CountW'(QUEUE_DEPTH - 1) : count_q;

	assign cmd.push = accept && (operation == OP_PUSH);
	assign cmd.pop  = accept && (operation == OP_POP) && !empty;

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		// Left neighbor: the head has none and never receives a shifted entry.
		if (i == 0) begin : g_head
			assign lgt_w[i]  = 1'b0;
			assign lkey_w[i] = '0;
			assign lpay_w[i] = '0;
		end else begin : g_body
			assign lgt_w[i]  = gt_w[i-1];
			assign lkey_w[i] = key_w[i-1];
			assign lpay_w[i] = pay_w[i-1];
		end

		// Right neighbor: the tail keeps its own entry on a pop, which then
		// lies beyond the fill level and is never read.
		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign rkey_w[i] = key_w[i];
			assign rpay_w[i] = pay_w[i];
		end else begin : g_inner
			assign rkey_w[i] = key_w[i+1];
			assign rpay_w[i] = pay_w[i+1];
		end

		bspq_cell #(
			.KEY_BITS     (KEY_BITS),
			.PAYLOAD_BITS (PAYLOAD_BITS),
			.COUNT_W      (CountW),
			.INDEX        (i)
		) u_cell (
			.clk           (clk),
			.cmd           (cmd),
			.fill          (fill),
			.new_key       (priority_req),
			.new_payload   (payload),
			.left_gt       (lgt_w[i]),
			.left_key      (lkey_w[i]),
			.left_payload  (lpay_w[i]),
			.right_key     (rkey_w[i]),
			.right_payload (rpay_w[i]),
			.gt            (gt_w[i]),
			.key           (key_w[i]),
			.payload       (pay_w[i])
		);
	end

	// Fill level and the done strobe carry reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= accept;
			if (cmd.push) begin
				count_q <= fill + CountW'(1);
			end else if (cmd.pop) begin
				count_q <= count_q - CountW'(1);
			end
		end
	end

	// Result payload is captured on every transfer; the head entry is read
	// before the row shifts it away.
	always_ff @(posedge clk) begin
		if (accept) begin
			if (operation == OP_PUSH) begin
				status_q <= full ? ST_PUSHED_DROP : ST_PUSHED;
				ppri_q   <= '0;
				ppay_q   <= '0;
			end else if (empty) begin
				status_q <= ST_POP_EMPTY;
				ppri_q   <= '0;
				ppay_q   <= '0;
			end else begin
				status_q <= ST_POPPED;
				ppri_q   <= key_w[0];
				ppay_q   <= pay_w[0];
			end
		end
	end

	assign done            = done_q;
	assign status          = status_q;
	assign popped_priority = ppri_q;
	assign popped_payload  = ppay_q;
	// The fill level already reflects the reported transfer while done is high.
	assign count           = COUNT_OUT_BITS'(count_q);

endmodule

>>> design/bspq_checker.sv
// ----------------------------------------------------------------------------
// bspq_checker
// Port-level checks for the bounded sorted priority queue, bound to the core.
// ----------------------------------------------------------------------------
`include "bounded_sorted_priority_queue_core_macros.svh"

module bspq_checker #(
	parameter int PAYLOAD_BITS = bspq_pkg::PAYLOAD_BITS_DEF,
	parameter int KEY_BITS     = bspq_pkg::KEY_BITS_DEF
) (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 start,
	input logic                                 busy,
	input logic                                 done,
	input logic [1:0]                           status,
	input logic signed [KEY_BITS-1:0]           popped_priority,
	input logic [PAYLOAD_BITS-1:0]              popped_payload,
	input logic [bspq_pkg::COUNT_OUT_BITS-1:0]  count
);

	import bspq_pkg::*;

	// Every transfer yields a result in the next cycle, and nothing else does.
	`BSPQ_ASSERT_NEXT(a_result_follows, start && !busy, done, "transfer without result")
	`BSPQ_ASSERT_NEXT(a_no_spurious, !(start && !busy), !done, "result without transfer")

	// A pop on an empty queue leaves it empty.
	`BSPQ_ASSERT_SAME(a_empty_pop_count, done && (status == ST_POP_EMPTY), count == '0,
		"empty pop with nonzero count")

	// Push results and empty pops carry zero popped fields.
	`BSPQ_ASSERT_SAME(a_push_zero_fields,
		done && (status == ST_PUSHED || status == ST_PUSHED_DROP || status == ST_POP_EMPTY),
		popped_priority == '0 && popped_payload == '0, "nonzero popped fields")

endmodule

bind bounded_sorted_priority_queue_core bspq_checker #(
	.PAYLOAD_BITS (PAYLOAD_BITS),
	.KEY_BITS     (KEY_BITS)
) u_bspq_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.start           (start),
	.busy            (busy),
	.done            (done),
	.status          (status),
	.popped_priority (popped_priority),
	.popped_payload  (popped_payload),
	.count           (count)
);

>>> sim/tb_bounded_sorted_priority_queue_core.sv
// ----------------------------------------------------------------------------
// tb_bounded_sorted_priority_queue_core
// Self-checking testbench for the bounded sorted priority queue core.
// ----------------------------------------------------------------------------
// A queue of push and pop commands is built up front: a short directed list
// (pops on empty, extreme keys and payloads, equal keys) followed by random
// episodes that fill the queue past full, mix pushes and pops, and drain it
// past empty. A clocked driver issues the commands with random idle cycles
// and, for every accepted transfer, runs a behavioral copy of the sorted
// queue to work out the result. A clocked monitor compares every result
// strobe against the oldest outstanding prediction, field by field.
// ----------------------------------------------------------------------------
module tb_bounded_sorted_priority_queue_core;
	timeunit 1ns;
	timeprecision 1ps;

	import bspq_pkg::*;

	localparam int DEPTH        = QUEUE_DEPTH_DEF;
	localparam int KEY_W        = KEY_BITS_DEF;
	localparam int DATA_W       = PAYLOAD_BITS_DEF;
	localparam int CNT_W        = COUNT_OUT_BITS;
	localparam int RANDOM_ITEMS = 1350;
	localparam int PHASE_ITEMS  = 150;
	localparam longint CYCLE_LIMIT = 100000;

	// One command as the sender presents it.
	typedef struct {
		logic                     op;
		logic signed [KEY_W-1:0]  key;
		logic [DATA_W-1:0]        data;
	} queue_cmd_t;

	// One predicted result, tagged with the cycle its transfer was taken in.
	typedef struct {
		bspq_status_t             st;
		logic signed [KEY_W-1:0]  pkey;
		logic [DATA_W-1:0]        pdata;
		logic [CNT_W-1:0]         cnt;
		longint                   accept_cycle;
	} queue_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic operation = OP_PUSH;
	logic signed [KEY_W-1:0] priority_req = '0;
	logic [DATA_W-1:0] payload = '0;
	logic busy;
	logic done;
	logic [1:0] status;
	logic signed [KEY_W-1:0] popped_priority;
	logic [DATA_W-1:0] popped_payload;
	logic [CNT_W-1:0] count;

	bounded_sorted_priority_queue_core u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.operation       (operation),
		.priority_req    (priority_req),
		.payload         (payload),
		.done            (done),
		.status          (status),
		.popped_priority (popped_priority),
		.popped_payload  (popped_payload),
		.count           (count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Commands waiting to be issued, and predictions waiting for their result.
	queue_cmd_t    cmd_backlog[$];
	queue_result_t expected_results[$];

	// Behavioral copy of the sorted row: keys ascending, equal keys in
	// arrival order. Only slots below sorted_fill are meaningful.
	logic signed [KEY_W-1:0] sorted_keys [DEPTH];
	logic [DATA_W-1:0]       sorted_data [DEPTH];
	int                      sorted_fill = 0;

	queue_cmd_t    on_port;
	queue_result_t next_result;
	queue_cmd_t    drive_cmd;
	int            accepted = 0;
	int            idle_pct = 0;
	int            errors = 0;
	longint        cycles = 0;
	int            gen_fill = 0;
	int            random_items = 0;

	// Applies one command to the copy of the row and returns its result.
	function automatic queue_result_t sort_and_apply(queue_cmd_t c);
		queue_result_t r;
		int n;
		int pos;
		r.pkey = '0;
		r.pdata = '0;
		r.accept_cycle = 0;
		if (c.op == OP_PUSH) begin
			n = sorted_fill;
			r.st = ST_PUSHED;
			// A push into a full row throws away the worst entry first.
			if (n >= DEPTH) begin
				n = DEPTH - 1;
				r.st = ST_PUSHED_DROP;
			end
			pos = n;
			// Strict less-than keeps equal keys behind the older ones.
			while (pos > 0 && c.key < sorted_keys[pos-1]) begin
				sorted_keys[pos] = sorted_keys[pos-1];
				sorted_data[pos] = sorted_data[pos-1];
				pos--;
			end
			sorted_keys[pos] = c.key;
			sorted_data[pos] = c.data;
			sorted_fill = n + 1;
		end else if (sorted_fill == 0) begin
			r.st = ST_POP_EMPTY;
		end else begin
			r.st = ST_POPPED;
			r.pkey = sorted_keys[0];
			r.pdata = sorted_data[0];
			sorted_fill--;
			for (int i = 0; i < sorted_fill; i++) begin
				sorted_keys[i] = sorted_keys[i+1];
				sorted_data[i] = sorted_data[i+1];
			end
		end
		r.cnt = CNT_W'(sorted_fill);
		return r;
	endfunction

	// Queues one command and keeps a rough fill level for shaping episodes.
	task automatic add_cmd(logic op, logic signed [KEY_W-1:0] key, logic [DATA_W-1:0] data);
		queue_cmd_t c;
		c.op = op;
		c.key = key;
		c.data = data;
		cmd_backlog.push_back(c);
		if (op == OP_PUSH) begin
			if (gen_fill < DEPTH)
				gen_fill++;
		end else if (gen_fill > 0) begin
			gen_fill--;
		end
	endtask

	// Keys lean on a narrow band so that ties are common, with the extremes
	// and the full range mixed in.
	function automatic logic signed [KEY_W-1:0] pick_key();
		case ($urandom_range(0, 9)) inside
			0: return {1'b1, {(KEY_W-1){1'b0}}};
			1: return {1'b0, {(KEY_W-1){1'b1}}};
			[2:5]: return KEY_W'(int'($urandom_range(0, 7)) - 4);
			default: return KEY_W'($urandom);
		endcase
	endfunction

	function automatic logic [DATA_W-1:0] pick_data();
		case ($urandom_range(0, 19))
			0: return '0;
			1: return '1;
			default: return DATA_W'($urandom);
		endcase
	endfunction

	task automatic add_random(int push_pct);
		if ($urandom_range(0, 99) < push_pct)
			add_cmd(OP_PUSH, pick_key(), pick_data());
		else
			add_cmd(OP_POP, pick_key(), pick_data());
		random_items++;
	endtask

	// Free-running cycle count; also the watchdog for a hung run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Driver. A transfer happens at an edge where start is high and busy is
	// low; at that edge the command on the ports is run through the copy of
	// the row and the prediction is queued. The next command, or an idle
	// cycle, is then put on the ports. The idle rate steps through phases as
	// transfers go by: none, half, none, and about one in five.
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				next_result = sort_and_apply(on_port);
				next_result.accept_cycle = cycles;
				expected_results.push_back(next_result);
				accepted++;
				case ((accepted / PHASE_ITEMS) % 4)
					0: idle_pct = 0;
					1: idle_pct = 50;
					2: idle_pct = 0;
					default: idle_pct = 18;
				endcase
			end
			if (!start || !busy) begin
				if (cmd_backlog.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
					drive_cmd = cmd_backlog.pop_front();
					on_port = drive_cmd;
					start <= 1'b1;
					operation <= drive_cmd.op;
					priority_req <= drive_cmd.key;
					payload <= drive_cmd.data;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	task automatic report_mismatch(string field, logic [DATA_W-1:0] exp_v,
			logic [DATA_W-1:0] act_v);
		$display("%0t: %s mismatch, expected %h, actual %h", $time, field, exp_v, act_v);
		errors++;
	endtask

	// Monitor. A result strobe must match the oldest prediction whose
	// transfer was taken at an earlier edge than this one.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_results.size() == 0 || expected_results[0].accept_cycle >= cycles) begin
				$display("%0t: result with no transfer outstanding, actual status %0d count %0d",
					$time, status, count);
				errors++;
			end else begin
				next_result = expected_results.pop_front();
				if (status !== next_result.st)
					report_mismatch("status", DATA_W'(next_result.st), DATA_W'(status));
				if (popped_priority !== next_result.pkey)
					report_mismatch("popped_priority", DATA_W'(next_result.pkey),
						DATA_W'(popped_priority));
				if (popped_payload !== next_result.pdata)
					report_mismatch("popped_payload", next_result.pdata, popped_payload);
				if (count !== next_result.cnt)
					report_mismatch("count", DATA_W'(next_result.cnt), DATA_W'(count));
			end
		end
	end

	initial begin
		int episode;
		int extra;
		int len;

		// Directed part: pop on empty, both key extremes, both payload
		// extremes, ties that must leave in arrival order, a full drain and
		// a second pop on empty.
		add_cmd(OP_POP, '0, '0);
		add_cmd(OP_PUSH, {1'b1, {(KEY_W-1){1'b0}}}, '0);
		add_cmd(OP_PUSH, {1'b0, {(KEY_W-1){1'b1}}}, '1);
		add_cmd(OP_PUSH, '0, 32'h5a5a_5a5a);
		add_cmd(OP_PUSH, '1, 32'ha5a5_a5a5);
		add_cmd(OP_PUSH, '0, 32'h0000_0001);
		add_cmd(OP_PUSH, '0, 32'h0000_0002);
		add_cmd(OP_PUSH, {1'b0, {(KEY_W-1){1'b1}}}, 32'h0000_0003);
		add_cmd(OP_PUSH, {1'b1, {(KEY_W-1){1'b0}}}, 32'h0000_0004);
		repeat (8)
			add_cmd(OP_POP, '1, '1);
		add_cmd(OP_POP, '0, '0);
		add_cmd(OP_PUSH, 16'sd1, 32'h1234_5678);
		add_cmd(OP_POP, '0, '0);

		// Random episodes: fill past full so that drops happen, churn in
		// the middle, then drain past empty. A share of the opposite
		// operation is mixed into each as noise.
		episode = 0;
		while (random_items < RANDOM_ITEMS) begin
			case (episode % 4)
				0: begin
					while (gen_fill < DEPTH)
						add_random(85);
					extra = $urandom_range(1, 12);
					repeat (extra)
						add_cmd(OP_PUSH, pick_key(), pick_data());
					random_items += extra;
				end
				2: begin
					while (gen_fill > 0)
						add_random(15);
					extra = $urandom_range(1, 3);
					repeat (extra)
						add_cmd(OP_POP, pick_key(), pick_data());
					random_items += extra;
				end
				default: begin
					len = $urandom_range(30, 120);
					repeat (len)
						add_random(50);
				end
			endcase
			episode++;
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Sample on the falling edge so that the driver's work at the rising
		// edge has fully settled.
		do
			@(negedge clk);
		while (cmd_backlog.size() != 0 || start || expected_results.size() != 0);
		repeat (4) @(posedge clk);

		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
